### sv/tpm_pkg.sv
// ---------------------------------------------------------------------------
// tpm_pkg: shared definitions for the true-peak meter
// Types, register codes, reset values and the polyphase prototype table
// used by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package tpm_pkg;

  // default geometry
  localparam int MAX_CHAN_DEF    = 8;
  localparam int PHASE_TAPS_DEF  = 12;
  localparam int OVERSAMPLE_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEFF_BITS_DEF  = 18;

  // fixed field widths
  localparam int CHAN_W     = 3;
  localparam int USER_IN_W  = 4;   // command, channel
  localparam int USER_OUT_W = 4;   // out_channel, accepted
  localparam int ACT_W      = 4;
  localparam int DECAY_W    = 24;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 24;

  // reset values of the configuration registers
  localparam logic [ACT_W-1:0]   ACT_RESET   = 4'd2;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 24'd16777011;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_CHANNELS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY_COEFF     = 1'b1;

  // item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // prototype: 48-tap windowed sinc, Q1.17; tap k of phase p is entry k*OS+p
  localparam int PROTO_LEN  = 48;
  localparam int PROTO_BITS = 18;
  localparam int PROTO [PROTO_LEN] = '{
         0,    -11,    -47,    -51,     93,    385,    560,    386,
      -563,  -1924,  -2658,  -1490,   1982,   6279,   8150,   4349,
     -5581, -17304, -22394, -12219,  16673,  58905, 101107, 127495,
    127495, 101107,  58905,  16673, -12219, -22394, -17304,  -5581,
      4349,   8150,   6279,   1982,  -1490,  -2658,  -1924,   -563,
       386,    560,    385,     93,    -51,    -47,    -11,      0
  };

  // prototype entry rescaled to cbits; narrower widths round half up
  function automatic int coeff_q(input int idx, input int cbits);
    int c;
    int s;
    c = 0;
    if (idx >= 0 && idx < PROTO_LEN) c = PROTO[idx];
    if (cbits >= PROTO_BITS) return c <<< (cbits - PROTO_BITS);
    s = PROTO_BITS - cbits;
    return (c + (1 <<< (s - 1))) >>> s;
  endfunction

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_DECAY,
    ST_FINISH
  } tpm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // take the input request
    logic hist_wr;    // write sample into history, arm the tap loop
    logic mac_issue;  // issue one tap read and multiply
    logic decay;      // apply the decay multiply
    logic finish;     // update channel state and load the result
  } tpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_active;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } tpm_status_t;

endpackage

### sv/tpm_ctrl.sv
// ---------------------------------------------------------------------------
// tpm_ctrl: sequencer of the true-peak meter
// Walks a request through decode, history write, the tap loop, pipeline drain,
// decay and result hand-off; clear and inactive requests skip to hand-off.
// ---------------------------------------------------------------------------
module tpm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  tpm_pkg::tpm_status_t  status,
  output tpm_pkg::tpm_cmd_t     cmd
);

  tpm_pkg::tpm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tpm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = tpm_pkg::ST_DECODE;
        end
      end
      tpm_pkg::ST_DECODE: begin
        if (status.is_clear || !status.is_active) begin
          state_nxt = tpm_pkg::ST_FINISH;
        end else begin
          state_nxt = tpm_pkg::ST_WRITE;
        end
      end
      tpm_pkg::ST_WRITE: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = tpm_pkg::ST_MAC;
      end
      tpm_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.issue_last) state_nxt = tpm_pkg::ST_DRAIN;
      end
      tpm_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = tpm_pkg::ST_DECAY;
      end
      tpm_pkg::ST_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = tpm_pkg::ST_FINISH;
      end
      tpm_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = tpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tpm_pkg::ST_IDLE;
    endcase
  end

endmodule

### sv/tpm_datapath.sv
// ---------------------------------------------------------------------------
// tpm_datapath: history memory, shared MAC and peak tracking
// Holds configuration, per-channel history and levels, one multiply-
// accumulate pipeline for the polyphase taps, decay and the result register.
// ---------------------------------------------------------------------------
module tpm_datapath #(
  parameter int MAX_CHAN    = tpm_pkg::MAX_CHAN_DEF,
  parameter int PHASE_TAPS  = tpm_pkg::PHASE_TAPS_DEF,
  parameter int OVERSAMPLE  = tpm_pkg::OVERSAMPLE_DEF,
  parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = tpm_pkg::COEFF_BITS_DEF,
  localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int PK_W       = SAMPLE_BITS + 1,
  localparam int OUT_W      = ((2 * PK_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tpm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input payload
  input  logic [tpm_pkg::USER_IN_W-1:0]     in_tuser,
  input  logic [IN_W-1:0]                   in_tdata,
  // control
  input  tpm_pkg::tpm_cmd_t                 cmd,
  output tpm_pkg::tpm_status_t              status,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tpm_pkg::USER_OUT_W-1:0]    out_tuser,
  output logic [OUT_W-1:0]                  out_tdata
);

  localparam int CH_W   = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
  localparam int K_W    = $clog2(PHASE_TAPS);
  localparam int P_W    = $clog2(OVERSAMPLE);
  localparam int F_W    = $clog2(PHASE_TAPS + 1);
  localparam int T_W    = $clog2(OVERSAMPLE * PHASE_TAPS);
  localparam int DEPTH  = MAX_CHAN * PHASE_TAPS;
  localparam int HA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + K_W;
  localparam int DW     = tpm_pkg::DECAY_W;
  localparam logic [PK_W-1:0] PK_MAX  = '1;
  localparam logic [ACC_W:0]  RND_HALF = (ACC_W + 1)'(1) << (COEFF_BITS - 2);

  // configuration registers
  logic [tpm_pkg::ACT_W-1:0] act_chan_r;
  logic [DW-1:0]             decay_coeff_r;

  // latched request
  logic                   cmd_r;
  logic [tpm_pkg::CHAN_W-1:0] chan_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  // per-channel state
  logic [K_W-1:0]  widx_r [MAX_CHAN];
  logic [F_W-1:0]  fill_r [MAX_CHAN];
  logic [PK_W-1:0] peak_r [MAX_CHAN];
  logic [PK_W-1:0] hold_r [MAX_CHAN];

  // history memory
  logic signed [SAMPLE_BITS-1:0] hist_mem [DEPTH];

  // tap loop
  logic [K_W-1:0] k_r;
  logic [P_W-1:0] p_r;
  logic [K_W-1:0] wr_pos_r;

  // MAC pipeline
  logic                          act1_r, first1_r, last1_r, hvld1_r;
  logic                          act2_r, first2_r, last2_r;
  logic                          end3_r, mag4_r;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic signed [COEFF_BITS-1:0]  coef1_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [ACC_W-1:0]              mag_r;
  logic [PK_W-1:0]               peak_work_r;
  logic [PK_W-1:0]               dec_r;

  // result register
  logic                       out_valid_r;
  logic [tpm_pkg::CHAN_W-1:0] out_chan_r;
  logic                       out_acc_r;
  logic [PK_W-1:0]            out_peak_r;
  logic [PK_W-1:0]            out_hold_r;

  // combinational
  logic [CH_W-1:0]     ch_idx;
  logic [7:0]          limit;
  logic                chan_live;
  logic [HA_W-1:0]     base_addr;
  logic [K_W-1:0]      h;
  logic [K_W:0]        h_wrap;
  logic [T_W-1:0]      tap_idx;
  logic signed [COEFF_BITS-1:0] coef_nxt;
  logic [ACC_W:0]      rnd_sum;
  logic [ACC_W:0]      rnd_sh;
  logic [PK_W-1:0]     cand;
  logic [PK_W+DW-1:0]  dec_prod;
  logic [PK_W-1:0]     hold_nxt;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_chan_r    <= tpm_pkg::ACT_RESET;
      decay_coeff_r <= tpm_pkg::DECAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        tpm_pkg::REG_ACTIVE_CHANNELS: act_chan_r    <= cfg_data[tpm_pkg::ACT_W-1:0];
        tpm_pkg::REG_DECAY_COEFF:     decay_coeff_r <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_tuser[0];
      chan_r   <= in_tuser[tpm_pkg::USER_IN_W-1:1];
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
  end

  // channel decode; active_channels saturates at MAX_CHAN
  assign ch_idx    = CH_W'(chan_r);
  assign limit     = ({4'b0, act_chan_r} < 8'(MAX_CHAN)) ? {4'b0, act_chan_r} : 8'(MAX_CHAN);
  assign chan_live = {5'b0, chan_r} < 8'(MAX_CHAN);
  assign base_addr = HA_W'(ch_idx) * HA_W'(PHASE_TAPS);

  assign status.is_clear   = (cmd_r == tpm_pkg::CMD_CLEAR);
  assign status.is_active  = {5'b0, chan_r} < limit;
  assign status.issue_last = (k_r == K_W'(PHASE_TAPS - 1)) && (p_r == P_W'(OVERSAMPLE - 1));
  assign status.pipe_busy  = act1_r | act2_r | end3_r | mag4_r;
  assign status.out_free   = !out_valid_r || out_tready;

  // history slot of tap k, newest first
  assign h_wrap = {1'b0, wr_pos_r} + (K_W + 1)'(PHASE_TAPS) - {1'b0, k_r};
  assign h      = (wr_pos_r >= k_r) ? (wr_pos_r - k_r) : h_wrap[K_W-1:0];

  // coefficient for tap k of phase p
  assign tap_idx  = T_W'(k_r) * T_W'(OVERSAMPLE) + T_W'(p_r);
  assign coef_nxt = COEFF_BITS'(tpm_pkg::coeff_q(int'(tap_idx), COEFF_BITS));

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.hist_wr) hist_mem[base_addr + HA_W'(widx_r[ch_idx])] <= sample_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      hist_q  <= hist_mem[base_addr + HA_W'(h)];
      coef1_r <= coef_nxt;
    end
  end

  // tap and phase counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      p_r <= '0;
    end else if (cmd.hist_wr) begin
      k_r <= '0;
      p_r <= '0;
    end else if (cmd.mac_issue) begin
      if (k_r == K_W'(PHASE_TAPS - 1)) begin
        k_r <= '0;
        p_r <= p_r + P_W'(1);
      end else begin
        k_r <= k_r + K_W'(1);
      end
    end
  end

  // pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act1_r   <= 1'b0;
      first1_r <= 1'b0;
      last1_r  <= 1'b0;
      hvld1_r  <= 1'b0;
      act2_r   <= 1'b0;
      first2_r <= 1'b0;
      last2_r  <= 1'b0;
      end3_r   <= 1'b0;
      mag4_r   <= 1'b0;
    end else begin
      act1_r   <= cmd.mac_issue;
      first1_r <= (k_r == '0);
      last1_r  <= (k_r == K_W'(PHASE_TAPS - 1));
      hvld1_r  <= F_W'(h) < fill_r[ch_idx];
      act2_r   <= act1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      end3_r   <= act2_r & last2_r;
      mag4_r   <= end3_r;
    end
  end

  // magnitude rounding and saturation
  assign rnd_sum = {1'b0, mag_r} + RND_HALF;
  assign rnd_sh  = rnd_sum >> (COEFF_BITS - 1);
  assign cand    = (rnd_sh > (ACC_W + 1)'(PK_MAX)) ? PK_MAX : rnd_sh[PK_W-1:0];

  // multiply, accumulate, magnitude, peak raise; unwritten slots read as signed zero
  always_ff @(posedge clk) begin
    prod_r <= (hvld1_r ? hist_q : SAMPLE_BITS'(0)) * coef1_r;
    if (act2_r) acc_r <= (first2_r ? '0 : acc_r) + ACC_W'(prod_r);
    if (end3_r) mag_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    if (cmd.hist_wr) begin
      peak_work_r <= peak_r[ch_idx];
      wr_pos_r    <= widx_r[ch_idx];
    end else if (mag4_r && (cand > peak_work_r)) begin
      peak_work_r <= cand;
    end
    if (cmd.decay) dec_r <= dec_prod[PK_W+DW-1:DW];
  end

  // decay: truncated Q0.24 multiply
  assign dec_prod = (PK_W + DW)'(peak_work_r) * (PK_W + DW)'(decay_coeff_r);
  assign hold_nxt = (dec_r > hold_r[ch_idx]) ? dec_r : hold_r[ch_idx];

  // per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHAN; i++) begin
        widx_r[i] <= '0;
        fill_r[i] <= '0;
        peak_r[i] <= '0;
        hold_r[i] <= '0;
      end
    end else begin
      if (cmd.hist_wr) begin
        widx_r[ch_idx] <= (widx_r[ch_idx] == K_W'(PHASE_TAPS - 1)) ? '0
                          : widx_r[ch_idx] + K_W'(1);
        if (fill_r[ch_idx] != F_W'(PHASE_TAPS)) fill_r[ch_idx] <= fill_r[ch_idx] + F_W'(1);
      end
      if (cmd.finish) begin
        if (status.is_clear) begin
          for (int i = 0; i < MAX_CHAN; i++) hold_r[i] <= '0;
        end else if (status.is_active) begin
          peak_r[ch_idx] <= dec_r;
          hold_r[ch_idx] <= hold_nxt;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_chan_r <= chan_r;
      if (status.is_clear) begin
        out_acc_r  <= 1'b1;
        out_peak_r <= chan_live ? peak_r[ch_idx] : '0;
        out_hold_r <= '0;
      end else if (status.is_active) begin
        out_acc_r  <= 1'b1;
        out_peak_r <= dec_r;
        out_hold_r <= hold_nxt;
      end else begin
        out_acc_r  <= 1'b0;
        out_peak_r <= '0;
        out_hold_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_acc_r, out_chan_r};
  assign out_tdata  = OUT_W'({out_hold_r, out_peak_r});

endmodule

### sv/true_peak_meter_4x_polyphase.sv
// A sample request runs every tap of every phase before out_tvalid; clear and
//   inactive-channel requests skip the tap loop.
// Throughput: one request at a time; all taps use the single shared MAC unit.
// Reset: rst_n synchronous, active low; clears levels, fill counts and config.
// ---------------------------------------------------------------------------
// true_peak_meter_4x_polyphase: per-channel true-peak meter
// Polyphase 4x interpolation over a circular history per channel, decaying
// peak with max-hold, a command clearing max-hold on all channels, and channel gating.
// ---------------------------------------------------------------------------
module true_peak_meter_4x_polyphase #(
  parameter int MAX_CHAN    = tpm_pkg::MAX_CHAN_DEF,
  parameter int PHASE_TAPS  = tpm_pkg::PHASE_TAPS_DEF,
  parameter int OVERSAMPLE  = tpm_pkg::OVERSAMPLE_DEF,
  parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = tpm_pkg::COEFF_BITS_DEF,
  localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * (SAMPLE_BITS + 1) + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tpm_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tpm_pkg::USER_IN_W-1:0]  in_tuser,   // [0] command, [3:1] channel
  input  logic [IN_W-1:0]                in_tdata,   // sample
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tpm_pkg::USER_OUT_W-1:0] out_tuser,  // [2:0] out_channel, [3] accepted
  output logic [OUT_W-1:0]               out_tdata   // true_peak, then max_hold
);

  tpm_pkg::tpm_cmd_t    cmd;
  tpm_pkg::tpm_status_t status;

  tpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tpm_datapath #(
    .MAX_CHAN    (MAX_CHAN),
    .PHASE_TAPS  (PHASE_TAPS),
    .OVERSAMPLE  (OVERSAMPLE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result register overwritten");

  // decay only once the MAC pipeline has drained
  a_decay_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decay |-> !status.pipe_busy)
    else $error("decay applied before pipeline drained");

  // finishing a request always presents a result
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid)
    else $error("finished request produced no result");

endmodule

### dv/tb_true_peak_meter_4x_polyphase.sv
// ---------------------------------------------------------------------------
// tb_true_peak_meter_4x_polyphase: self-checking bench for the true-peak meter
// Drives sample and clear requests through the input stream. A cycle-free
// model of the polyphase interpolator, peak decay and max-hold predicts every
// result. Each result on the output stream is checked field by field against
// the oldest prediction. Phases vary channel gating, decay factor,
// sender gaps and receiver back-pressure.
// ---------------------------------------------------------------------------
module tb_true_peak_meter_4x_polyphase;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NCH           = 8;
  localparam int     TAPS          = 12;
  localparam int     PHASES        = 4;
  localparam longint PEAK_SAT      = (longint'(1) << 25) - 1;
  localparam int     CYCLE_LIMIT   = 1_500_000;
  localparam int     SETTLE_CYCLES = 70;

  // windowed sinc prototype, Q1.17; tap k of phase p sits at k*PHASES+p
  localparam int SINC_Q17 [48] = '{
         0,    -11,    -47,    -51,     93,    385,    560,    386,
      -563,  -1924,  -2658,  -1490,   1982,   6279,   8150,   4349,
     -5581, -17304, -22394, -12219,  16673,  58905, 101107, 127495,
    127495, 101107,  58905,  16673, -12219, -22394, -17304,  -5581,
      4349,   8150,   6279,   1982,  -1490,  -2658,  -1924,   -563,
       386,    560,    385,     93,    -51,    -47,    -11,      0
  };

  typedef struct packed {
    logic [2:0]  chan;
    logic        acc;
    logic [24:0] peak;
    logic [24:0] hold;
  } meter_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // block ports
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [tpm_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [tpm_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [tpm_pkg::USER_IN_W-1:0]  in_tuser   = '0;  // [0] command, [3:1] channel
  logic [23:0]                    in_tdata   = '0;  // [23:0] sample
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [tpm_pkg::USER_OUT_W-1:0] out_tuser;        // [2:0] out_channel, [3] accepted
  logic [55:0]                    out_tdata;        // [24:0] true_peak, [49:25] max_hold

  true_peak_meter_4x_polyphase u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // predicted meter state
  logic signed [23:0] hist_mem [NCH][TAPS];
  int                 wr_ptr   [NCH];
  longint             peak_lvl [NCH];
  longint             hold_lvl [NCH];
  int                 act_chans  = 2;
  longint             decay_mult = 16777011;

  meter_result_t meter_q [$];
  bit            swing_neg [NCH];
  int            err_cnt        = 0;
  int            cycle_cnt      = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  logic          recv_hold      = 1'b0;

  initial begin
    foreach (hist_mem[c, t]) hist_mem[c][t] = '0;
    foreach (wr_ptr[c]) begin
      wr_ptr[c]   = 0;
      peak_lvl[c] = 0;
      hold_lvl[c] = 0;
    end
  end

  // one request through the meter: interpolate, raise peak, decay, hold
  function automatic meter_result_t predict_meter(input logic cmd, input logic [2:0] ch,
                                                  input logic signed [23:0] smp);
    meter_result_t r;
    longint        acc;
    longint        mag;
    longint        pk;
    int            lim;
    int            p;
    int            k;
    r      = '0;
    r.chan = ch;
    lim    = (act_chans > NCH) ? NCH : act_chans;
    if (cmd == tpm_pkg::CMD_CLEAR) begin
      foreach (hold_lvl[i]) hold_lvl[i] = 0;
      r.acc  = 1'b1;
      r.peak = 25'(peak_lvl[ch]);
      return r;
    end
    if (int'(ch) >= lim) return r;
    hist_mem[ch][wr_ptr[ch]] = smp;
    wr_ptr[ch] = (wr_ptr[ch] + 1) % TAPS;
    pk = peak_lvl[ch];
    for (p = 0; p < PHASES; p++) begin
      acc = 0;
      for (k = 0; k < TAPS; k++)
        acc += longint'(hist_mem[ch][(wr_ptr[ch] + TAPS - 1 - k) % TAPS])
               * longint'(SINC_Q17[k * PHASES + p]);
      mag = (acc < 0) ? -acc : acc;
      mag = (mag + (longint'(1) << 16)) >>> 17;
      if (mag > PEAK_SAT) mag = PEAK_SAT;
      if (mag > pk) pk = mag;
    end
    pk = (pk * decay_mult) >>> 24;
    peak_lvl[ch] = pk;
    if (pk > hold_lvl[ch]) hold_lvl[ch] = pk;
    r.acc  = 1'b1;
    r.peak = 25'(pk);
    r.hold = 25'(hold_lvl[ch]);
    return r;
  endfunction

  // receiver: random stalls, or a held-off stretch
  always @(posedge clk)
    out_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic check_field(input string fname, input logic [24:0] want,
                             input logic [24:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (meter_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %h %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = meter_q.pop_front();
        check_field("out_channel", 25'(want.chan), 25'(out_tuser[2:0]));
        check_field("accepted",    25'(want.acc),  25'(out_tuser[3]));
        check_field("true_peak",   want.peak,      out_tdata[24:0]);
        check_field("max_hold",    want.hold,      out_tdata[49:25]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[true_peak_meter_4x_polyphase] ERROR");
      $finish;
    end
  end

  // offer one request, optionally after a gap; valid stays up on return
  task automatic send_request(input logic cmd, input logic [2:0] ch,
                              input logic signed [23:0] smp);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ch, cmd};
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    meter_q.push_back(predict_meter(cmd, ch, smp));
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (meter_q.size() != 0);
  endtask

  // write both registers back to back; only called with the block idle
  task automatic set_config(input logic [3:0] act, input logic [23:0] decay);
    cfg_valid <= 1'b1;
    cfg_addr  <= tpm_pkg::REG_ACTIVE_CHANNELS;
    cfg_data  <= {20'($urandom), act};
    do @(posedge clk); while (!cfg_ready);
    act_chans = act;
    cfg_addr  <= tpm_pkg::REG_DECAY_COEFF;
    cfg_data  <= decay;
    do @(posedge clk); while (!cfg_ready);
    decay_mult = longint'(decay);
    cfg_valid <= 1'b0;
  endtask

  // mostly active channels, with full-scale swings to provoke intersample peaks
  task automatic random_request();
    logic               cmd;
    logic [2:0]         ch;
    logic signed [23:0] smp;
    int                 lim;
    lim = (act_chans > NCH) ? NCH : act_chans;
    cmd = ($urandom_range(0, 99) < 6) ? tpm_pkg::CMD_CLEAR : tpm_pkg::CMD_SAMPLE;
    if (lim > 0 && $urandom_range(0, 99) < 85) ch = 3'($urandom_range(0, lim - 1));
    else ch = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: smp = 24'($urandom);
      4:          smp = 24'sh7FFFFF;
      5:          smp = 24'sh800000;
      6:          smp = 24'(int'($urandom_range(0, 512)) - 256);
      default: begin
        swing_neg[ch] = !swing_neg[ch];
        smp = 24'($urandom_range(24'h500000, 24'h7FFFFF));
        if (swing_neg[ch]) smp = -smp;
      end
    endcase
    send_request(cmd, ch, smp);
  endtask

  // corners: full scale, gating, clear, channel limits and decay extremes
  task automatic test_directed_corners();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // reset settings: two channels, near-unity decay
    send_request(tpm_pkg::CMD_SAMPLE, 3'd0, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd0, 24'sh800000);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd0, 24'sh000000);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd1, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd1, 24'sh800000);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd2, 24'sh123456);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd7, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_CLEAR,  3'd0, 24'sh000000);
    send_request(tpm_pkg::CMD_CLEAR,  3'd6, 24'shFFFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd0, 24'sh000001);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd0, 24'shFFFFFF);
    wait_drained();
    // nothing active; clear still goes through
    set_config(4'd0, 24'hFFFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd0, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_CLEAR,  3'd3, 24'sh000000);
    wait_drained();
    // count above the channel total, zero decay
    set_config(4'd15, 24'h000000);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd7, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd5, 24'sh800000);
    wait_drained();
    // all channels, full decay factor, alternating full scale
    set_config(4'd8, 24'hFFFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd7, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd7, 24'sh800000);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd7, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd3, 24'sh7FFFFF);
    send_request(tpm_pkg::CMD_CLEAR,  3'd7, 24'sh000000);
    send_request(tpm_pkg::CMD_SAMPLE, 3'd7, 24'sh000000);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
                                     input logic [3:0] act, input logic [23:0] decay);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    set_config(act, decay);
    repeat (n) random_request();
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    set_config(4'd8, tpm_pkg::DECAY_RESET);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (400) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    repeat (12) random_request();
    wait_drained();
  endtask

  // sender waits for every result between short bursts
  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_stall_pct <= 17;
    set_config(4'd6, 24'd16500000);
    repeat (4) begin
      repeat (5) random_request();
      wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_traffic(400, 0, 0, 4'd8, tpm_pkg::DECAY_RESET);
    test_random_traffic(400, 50, 0, 4'd4, 24'hFFFFFF);
    test_random_traffic(400, 0, 50, 4'd15, 24'($urandom));
    test_random_traffic(400, 17, 17, 4'd1, 24'd16000000);
    test_output_hold_off();
    test_random_traffic(150, 17, 17, 4'd3, 24'($urandom_range(24'hF00000, 24'hFFFFFF)));
    test_random_traffic(100, 0, 0, 4'd5, 24'h000000);
    test_random_traffic(40, 50, 50, 4'd0, tpm_pkg::DECAY_RESET);
    test_sender_pause();
    // catch stray results after the last one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("[true_peak_meter_4x_polyphase] OK");
    else
      $display("[true_peak_meter_4x_polyphase] ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/tpm_pkg.sv
sv/tpm_ctrl.sv
sv/tpm_datapath.sv
sv/true_peak_meter_4x_polyphase.sv
dv/tb_true_peak_meter_4x_polyphase.sv
